// ===== design/sosv_pkg.sv =====
// Shared types and constants for the spring oscillator Verlet stepper.
// No dependencies.
package sosv_pkg;

  localparam int unsigned ANGLE_LEN = 30;
  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

  typedef enum logic [2:0] {
    REG_RUN_ENABLE = 3'd0,
    REG_TIME_SCALE = 3'd1,
    REG_FIXED_STEP = 3'd2,
    REG_STIFFNESS  = 3'd3,
    REG_START_POS  = 3'd4,
    REG_START_VEL  = 3'd5,
    REG_PHASE_STEP = 3'd6
  } reg_idx_t;

  localparam logic OP_FRAME   = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Datapath commands from the controller.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_RESTART,
    CMD_SCALE,
    CMD_ACCUM,
    CMD_VA,
    CMD_VB,
    CMD_VC,
    CMD_VD,
    CMD_VE,
    CMD_VF,
    CMD_CORDIC_INIT,
    CMD_CORDIC_ITER,
    CMD_CORDIC_END,
    CMD_ERR_SQ,
    CMD_ERR_ADD
  } cmd_t;

  typedef struct packed {
    logic step_ok;  // leftover >= fixed_step
  } dp_status_t;

  function automatic logic [31:0] angle_at(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== design/sosv_if.sv =====
// Valid/ready channel interfaces for the stepper.
// Depends on nothing.
interface sosv_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [30:0] frame_time;
  modport source (output valid, op, frame_time, input ready);
  modport sink   (input valid, op, frame_time, output ready);
endinterface

interface sosv_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  logic signed [31:0] velocity;
  logic signed [31:0] analytic_position;
  logic [63:0]        error_sum;
  logic [4:0]         steps_taken;
  modport source (output valid, position, velocity, analytic_position, error_sum,
                  steps_taken, input ready);
  modport sink   (input valid, position, velocity, analytic_position, error_sum,
                  steps_taken, output ready);
endinterface

interface sosv_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/sosv_datapath.sv =====
// Datapath: state registers, shared multiplier, CORDIC rotator, error sum.
// Depends on sosv_pkg.
module sosv_datapath
  import sosv_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  logic [4:0]         iter,
  input  logic [30:0]        frame_time,
  input  logic [31:0]        time_scale,
  input  logic [30:0]        fixed_step,
  input  logic [30:0]        stiffness,
  input  logic signed [31:0] start_pos,
  input  logic signed [31:0] start_vel,
  input  logic [31:0]        phase_step,
  output dp_status_t         status,
  output logic signed [31:0] pos_o,
  output logic signed [31:0] vel_o,
  output logic signed [31:0] ana_o,
  output logic [63:0]        err_o
);

  logic signed [31:0] pos_r, vel_r, ana_r;
  logic signed [31:0] a_r, adt_r, nx_r;
  logic [31:0]        left_r, phase_r;
  logic [63:0]        err_r;
  logic signed [65:0] prod_r;   // registered product
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic [1:0]         quad_r;
  logic [63:0]        sq_r;

  // Shared multiplier: operands chosen by command, result registered.
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic signed [32:0] sdt, sw2;
  assign sdt = {2'b00, fixed_step};
  assign sw2 = {2'b00, stiffness};

  logic signed [65:0] fl;       // floor shift of previous product
  logic signed [31:0] fsat;
  assign fl   = prod_r >>> FRAC_BITS;
  assign fsat = sat32(fl);

  logic signed [32:0] diff;
  assign diff = 33'(pos_r) - 33'(ana_r);
  logic [32:0] mag;
  assign mag = diff[32] ? 33'(-diff) : 33'(diff);

  // Verlet intermediate held across the step
  logic signed [31:0] half_r;
  logic signed [31:0] na;
  logic signed [33:0] nxs;
  logic signed [65:0] vsum;
  logic signed [65:0] dvp;
  logic signed [31:0] cos_v;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd)
      CMD_SCALE:       begin ma = {2'b00, frame_time}; mb = {1'b0, time_scale}; end
      CMD_VA:          begin ma = sw2;  mb = 33'(pos_r); end
      // forward the value being registered this cycle
      CMD_VB:          begin ma = 33'(sat32(-fl));  mb = sdt; end
      CMD_VC:          begin ma = 33'(fsat); mb = sdt; end
      CMD_VD:          begin ma = 33'(vel_r); mb = sdt; end
      CMD_VE:          begin ma = sw2;  mb = 33'(sat32(66'(nxs))); end
      CMD_CORDIC_INIT: begin ma = 33'(start_pos); mb = 33'(CORDIC_GAIN_Q30); end
      default: ;
    endcase
  end
  assign prod = 66'(ma * mb);

  assign status.step_ok = left_r >= {1'b0, fixed_step};

  logic signed [33:0] dx, dy;
  logic [31:0] ang;
  assign dx  = cy_r >>> iter;
  assign dy  = cx_r >>> iter;
  assign ang = angle_at(iter);

  logic [31:0] pnext;
  assign pnext = phase_r + phase_step + 32'h2000_0000;

  // Residual phase captured with the step so CORDIC uses the new phase.
  logic [31:0] pnext_r;

  logic [64:0] esum;
  assign esum = {1'b0, err_r} + {1'b0, sq_r};

  always_comb begin
    unique case (quad_r)
      2'd0: cos_v = sat32(66'(cx_r));
      2'd1: cos_v = sat32(-66'(cy_r));
      2'd2: cos_v = sat32(-66'(cx_r));
      default: cos_v = sat32(66'(cy_r));
    endcase
  end

  assign na   = sat32(-fl);
  assign nxs  = 34'(pos_r) + 34'(fsat) + 34'(half_r);
  assign dvp  = 66'(34'(a_r) + 34'(na)) * 66'(sdt);
  assign vsum = 66'(vel_r) + (dvp >>> (FRAC_BITS + 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 32'sd65536;
      vel_r   <= '0;
      ana_r   <= 32'sd65536;
      left_r  <= '0;
      phase_r <= '0;
      err_r   <= '0;
    end else begin
      if (cmd != CMD_NONE) prod_r <= prod;
      unique case (cmd)
        CMD_RESTART: begin
          pos_r <= start_pos; vel_r <= start_vel; ana_r <= start_pos;
          left_r <= '0; phase_r <= '0; err_r <= '0;
        end
        CMD_ACCUM: begin
          // prod_r holds frame_time*time_scale
          if (fl > 66'sd4294967295 || 33'(left_r) + 33'(fl[31:0]) > 33'h0_ffff_ffff)
            left_r <= '1;
          else
            left_r <= left_r + fl[31:0];
        end
        CMD_VB: a_r <= sat32(-fl);
        CMD_VC: adt_r <= fsat;
        CMD_VD: half_r <= fsat >>> 1;
        CMD_VE: nx_r <= sat32(66'(nxs));
        CMD_VF: begin
          vel_r   <= sat32(vsum);
          pos_r   <= nx_r;
          left_r  <= left_r - {1'b0, fixed_step};
          phase_r <= phase_r + phase_step;
          quad_r  <= pnext[31:30];
        end
        CMD_CORDIC_INIT: begin
          cx_r <= 34'(prod >>> 30);
          cy_r <= '0;
          cz_r <= 34'($signed({4'b0, pnext_r[29:0]})) - 34'sh2000_0000;
        end
        CMD_CORDIC_ITER: begin
          if (!cz_r[33]) begin
            cx_r <= cx_r - dx; cy_r <= cy_r + dy; cz_r <= cz_r - 34'(ang);
          end else begin
            cx_r <= cx_r + dx; cy_r <= cy_r - dy; cz_r <= cz_r + 34'(ang);
          end
        end
        CMD_CORDIC_END: ana_r <= cos_v;
        CMD_ERR_SQ: sq_r <= 64'(mag) * 64'(mag);
        CMD_ERR_ADD: err_r <= esum[64] ? '1 : esum[63:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_VF) pnext_r <= pnext;
  end

  assign pos_o = pos_r;
  assign vel_o = vel_r;
  assign ana_o = ana_r;
  assign err_o = err_r;

endmodule

// ===== design/sosv_ctrl.sv =====
// Controller: sequences frame accumulation, Verlet steps, CORDIC and error sum.
// Depends on sosv_pkg.
module sosv_ctrl
  import sosv_pkg::*;
#(
  parameter int MAX_STEPS    = 16,
  parameter int CORDIC_ITERS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_op,
  output logic       in_ready,
  input  logic       run_enable,
  input  dp_status_t status,
  output cmd_t       cmd,
  output logic [4:0] iter,
  output logic [6:0] steps,
  output logic       done,
  input  logic       out_free
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCALE, S_ACCUM, S_CHECK, S_VA, S_VB, S_VC, S_VD, S_VE, S_VF,
    S_CINIT, S_CITER, S_CEND, S_ESQ, S_EADD, S_DONE
  } state_t;

  localparam int NITER = (CORDIC_ITERS < ANGLE_LEN) ? CORDIC_ITERS : ANGLE_LEN;

  state_t     state_r;
  logic [4:0] iter_r;
  logic [6:0] steps_r;

  assign in_ready = (state_r == S_IDLE) && out_free;
  assign iter  = iter_r;
  assign steps = steps_r;
  assign done  = state_r == S_DONE;

  always_comb begin
    unique case (state_r)
      S_SCALE: cmd = CMD_SCALE;
      S_ACCUM: cmd = CMD_ACCUM;
      S_VA:    cmd = CMD_VA;
      S_VB:    cmd = CMD_VB;
      S_VC:    cmd = CMD_VC;
      S_VD:    cmd = CMD_VD;
      S_VE:    cmd = CMD_VE;
      S_VF:    cmd = CMD_VF;
      S_CINIT: cmd = CMD_CORDIC_INIT;
      S_CITER: cmd = CMD_CORDIC_ITER;
      S_CEND:  cmd = CMD_CORDIC_END;
      S_ESQ:   cmd = CMD_ERR_SQ;
      S_EADD:  cmd = CMD_ERR_ADD;
      S_IDLE:  cmd = (in_valid && in_ready && in_op == OP_RESTART) ? CMD_RESTART
                                                                  : CMD_NONE;
      default: cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iter_r  <= '0;
      steps_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          steps_r <= '0;
          state_r <= (in_op == OP_FRAME && run_enable) ? S_SCALE : S_DONE;
        end
        S_SCALE: state_r <= S_ACCUM;
        S_ACCUM: state_r <= S_CHECK;
        S_CHECK: state_r <= (status.step_ok && 32'(steps_r) < MAX_STEPS) ? S_VA : S_DONE;
        S_VA: state_r <= S_VB;
        S_VB: state_r <= S_VC;
        S_VC: state_r <= S_VD;
        S_VD: state_r <= S_VE;
        S_VE: state_r <= S_VF;
        S_VF: state_r <= S_CINIT;
        S_CINIT: begin iter_r <= '0; state_r <= S_CITER; end
        S_CITER: begin
          iter_r <= iter_r + 5'd1;
          if (32'(iter_r) == NITER - 1) state_r <= S_CEND;
        end
        S_CEND: state_r <= S_ESQ;
        S_ESQ:  state_r <= S_EADD;
        S_EADD: begin steps_r <= steps_r + 7'd1; state_r <= S_CHECK; end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/spring_oscillator_verlet_stepper.sv =====
// Top level of the spring oscillator Verlet stepper: config registers,
// controller, datapath and output register. Depends on sosv_pkg, sosv_if.
//
//   channel | dir | carries
//   in_     | in  | op, frame_time
//   out_    | out | position, velocity, analytic_position, error_sum, steps_taken
//   cfg_    | in  | index, data
//
// A restart or idle frame goes straight to DONE; a frame runs SCALE and ACCUM,
// then per Verlet step the VA-VF multiplier sequence, the one-bit-per-cycle
// CORDIC rotator and the error square and sum. Reset is synchronous; one item is
// in work at a time; input waits while busy or while the output register is full.
module spring_oscillator_verlet_stepper
  import sosv_pkg::*;
#(
  parameter int MAX_STEPS    = 16,
  parameter int CORDIC_ITERS = 16,
  parameter int FRAC_BITS    = 16
) (
  input logic        clk,
  input logic        rst_n,
  sosv_in_if.sink    in_ch,
  sosv_out_if.source out_ch,
  sosv_cfg_if.sink   cfg_ch
);

  logic        run_enable_r;
  logic [31:0] time_scale_r, phase_step_r;
  logic [30:0] fixed_step_r, stiffness_r;
  logic signed [31:0] start_pos_r, start_vel_r;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_enable_r <= 1'b1;
      time_scale_r <= 32'd65536;
      fixed_step_r <= 31'd655;
      stiffness_r  <= 31'd65536;
      start_pos_r  <= 32'sd65536;
      start_vel_r  <= '0;
      phase_step_r <= 32'd6835519;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_RUN_ENABLE: run_enable_r <= cfg_ch.data[0];
        REG_TIME_SCALE: time_scale_r <= cfg_ch.data;
        REG_FIXED_STEP: fixed_step_r <= cfg_ch.data[30:0];
        REG_STIFFNESS:  stiffness_r  <= cfg_ch.data[30:0];
        REG_START_POS:  start_pos_r  <= cfg_ch.data;
        REG_START_VEL:  start_vel_r  <= cfg_ch.data;
        REG_PHASE_STEP: phase_step_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  cmd_t       cmd;
  logic [4:0] iter;
  logic [6:0] steps;
  logic       done;
  dp_status_t status;
  logic signed [31:0] pos, vel, ana;
  logic [63:0] err;
  logic out_valid_r;
  logic [30:0] frame_time_r;

  sosv_ctrl #(.MAX_STEPS(MAX_STEPS), .CORDIC_ITERS(CORDIC_ITERS)) u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_op(in_ch.op), .in_ready(in_ch.ready),
    .run_enable(run_enable_r), .status, .cmd, .iter, .steps, .done,
    .out_free(!out_valid_r || out_ch.ready)
  );

  sosv_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n, .cmd, .iter, .frame_time(frame_time_r),
    .time_scale(time_scale_r), .fixed_step(fixed_step_r), .stiffness(stiffness_r),
    .start_pos(start_pos_r), .start_vel(start_vel_r), .phase_step(phase_step_r),
    .status, .pos_o(pos), .vel_o(vel), .ana_o(ana), .err_o(err)
  );

  // Hold frame time from acceptance; the multiplier uses it in the SCALE cycle.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) frame_time_r <= in_ch.frame_time;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (done) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (done) begin
      out_ch.position          <= pos;
      out_ch.velocity          <= vel;
      out_ch.analytic_position <= ana;
      out_ch.error_sum         <= err;
      out_ch.steps_taken       <= steps[4:0];
    end
  end
  assign out_ch.valid = out_valid_r;

  // done only after the output register frees
  a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (!out_valid_r || out_ch.ready)) else $error("result overwritten");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !done) else $error("ready while busy");
  a_steps: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> 32'(steps) <= MAX_STEPS) else $error("step limit exceeded");

endmodule

// ===== verif/tb_spring_oscillator_verlet_stepper.sv =====
// Testbench for the spring oscillator Verlet stepper: drives config writes,
// frame and restart items with random idling, predicts each result in a
// scoreboard class. Depends on sosv_pkg, sosv_if and the stepper RTL.
module tb_spring_oscillator_verlet_stepper;
  import sosv_pkg::*;

  localparam int STEP_LIMIT   = 16;
  localparam int ROTATIONS    = 16;
  localparam int FRAC         = 16;
  localparam int WATCHDOG_MAX = 20000;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] analytic_position;
    logic [63:0]        error_sum;
    logic [4:0]         steps_taken;
  } osc_result_t;

  // Fixed-point helpers for the stepper prediction.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return clamp32(floor_shift(a * b, FRAC));
  endfunction

  class oscillator_scoreboard;
    bit             run_on;
    bit [31:0]      scale;
    bit [30:0]      dt;
    bit [30:0]      w2;
    longint         x0, v0;
    bit [31:0]      dphase;
    longint         pos, vel, ana;
    bit [31:0]      left_time, phase;
    bit [63:0]      err;
    osc_result_t    pending[$];
    int             errors;

    function void reset_state();
      run_on = 1; scale = 65536; dt = 655; w2 = 65536;
      x0 = 65536; v0 = 0; dphase = 6835519;
      pos = 65536; vel = 0; ana = 65536; left_time = 0; phase = 0; err = 0;
    endfunction

    function void write_reg(reg_idx_t idx, bit [31:0] d);
      case (idx)
        REG_RUN_ENABLE: run_on = d[0];
        REG_TIME_SCALE: scale = d;
        REG_FIXED_STEP: dt = d[30:0];
        REG_STIFFNESS:  w2 = d[30:0];
        REG_START_POS:  x0 = longint'($signed(d));
        REG_START_VEL:  v0 = longint'($signed(d));
        REG_PHASE_STEP: dphase = d;
        default: ;
      endcase
    endfunction

    function longint cosine_of(bit [31:0] ph);
      bit [31:0] p;
      bit [1:0] quad;
      longint z, cx, cy, dx, dy;
      p = ph + 32'h2000_0000;
      quad = p[31:30];
      z = longint'(p[29:0]) - 64'sh2000_0000;
      cx = floor_shift(x0 * longint'(CORDIC_GAIN_Q30), 30);
      cy = 0;
      for (int i = 0; i < ROTATIONS; i++) begin
        dx = floor_shift(cy, i);
        dy = floor_shift(cx, i);
        if (z >= 0) begin
          cx -= dx; cy += dy; z -= longint'(angle_at(i[4:0]));
        end else begin
          cx += dx; cy -= dy; z += longint'(angle_at(i[4:0]));
        end
      end
      case (quad)
        2'd0: return clamp32(cx);
        2'd1: return clamp32(-cy);
        2'd2: return clamp32(-cx);
        default: return clamp32(cy);
      endcase
    endfunction

    function void verlet_advance();
      longint a, adt, half, nx, na, dv, diff;
      bit [63:0] mag, sq;
      a = clamp32(-floor_shift(longint'(w2) * pos, FRAC));
      adt = qmul(a, longint'(dt));
      half = floor_shift(qmul(adt, longint'(dt)), 1);
      nx = clamp32(pos + qmul(vel, longint'(dt)) + half);
      na = clamp32(-floor_shift(longint'(w2) * nx, FRAC));
      dv = floor_shift((a + na) * longint'(dt), FRAC + 1);
      vel = clamp32(vel + dv);
      pos = nx;
      phase += dphase;
      ana = cosine_of(phase);
      diff = pos - ana;
      mag = (diff < 0) ? -diff : diff;
      sq = mag * mag;
      err = (err > ~64'd0 - sq) ? ~64'd0 : err + sq;
    endfunction

    function void note_item(logic op, bit [30:0] ft);
      osc_result_t r;
      bit [63:0] scaled, total;
      int n;
      n = 0;
      if (op == OP_RESTART) begin
        pos = x0; vel = v0; left_time = 0; phase = 0; ana = x0; err = 0;
      end else if (run_on) begin
        scaled = (64'(ft) * 64'(scale)) >> FRAC;
        if (scaled > 64'hFFFF_FFFF) scaled = 64'hFFFF_FFFF;
        total = 64'(left_time) + scaled;
        left_time = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
        while (n < STEP_LIMIT && left_time >= 32'(dt)) begin
          verlet_advance();
          left_time -= 32'(dt);
          n++;
        end
      end
      r.position = pos[31:0];
      r.velocity = vel[31:0];
      r.analytic_position = ana[31:0];
      r.error_sum = err;
      r.steps_taken = n[4:0];
      pending.push_back(r);
    endfunction

    function void check_result(osc_result_t got);
      osc_result_t exp_r;
      if (pending.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.position !== exp_r.position) begin
        $error("position exp %0d got %0d", exp_r.position, got.position); errors++;
      end
      if (got.velocity !== exp_r.velocity) begin
        $error("velocity exp %0d got %0d", exp_r.velocity, got.velocity); errors++;
      end
      if (got.analytic_position !== exp_r.analytic_position) begin
        $error("analytic_position exp %0d got %0d", exp_r.analytic_position,
               got.analytic_position); errors++;
      end
      if (got.error_sum !== exp_r.error_sum) begin
        $error("error_sum exp %0d got %0d", exp_r.error_sum, got.error_sum); errors++;
      end
      if (got.steps_taken !== exp_r.steps_taken) begin
        $error("steps_taken exp %0d got %0d", exp_r.steps_taken, got.steps_taken);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  always #10 clk = ~clk;

  sosv_in_if  in_ch();
  sosv_out_if out_ch();
  sosv_cfg_if cfg_ch();

  spring_oscillator_verlet_stepper u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  oscillator_scoreboard board = new();
  int  idle_pct = 35;
  int  quiet_cycles = 0;
  bit  watchdog_fired = 0;

  initial begin
    in_ch.valid = 0; in_ch.op = OP_FRAME; in_ch.frame_time = '0;
    out_ch.ready = 0;
    cfg_ch.valid = 0; cfg_ch.index = REG_RUN_ENABLE; cfg_ch.data = '0;
  end

  // Result side: random backpressure, check at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result({out_ch.position, out_ch.velocity, out_ch.analytic_position,
                          out_ch.error_sum, out_ch.steps_taken});
  end

  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 0;
    else out_ch.ready <= ($urandom_range(99) >= idle_pct);
  end

  // Count cycles without any accepted item.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX && !watchdog_fired) begin
        watchdog_fired = 1;
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Valid stays high after acceptance so items can follow back to back;
  // idling or drain drops it.
  task automatic send_item(logic op, bit [30:0] ft);
    cfg_ch.valid <= 0;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1; in_ch.op <= op; in_ch.frame_time <= ft;
    do @(posedge clk); while (!in_ch.ready);
    board.note_item(op, ft);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    cfg_ch.valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    // all results are checked; idle before going on
    repeat (600) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, bit [31:0] d);
    cfg_ch.valid <= 1; cfg_ch.index <= idx; cfg_ch.data <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    board.write_reg(idx, d);
    @(negedge clk);
  endtask

  task automatic random_setting(bit extreme);
    write_reg(REG_RUN_ENABLE, 32'($urandom_range(9) != 0));
    write_reg(REG_TIME_SCALE, extreme ? (($urandom_range(1) != 0) ? 32'hFFFF_FFFF
                                                                  : 32'h8000_0000)
                                      : $urandom_range(40000, 140000));
    write_reg(REG_FIXED_STEP, extreme ? ($urandom_range(1) ? 32'h7FFF_FFFF : 32'd1)
                                      : $urandom_range(200, 3000));
    write_reg(REG_STIFFNESS, extreme ? ($urandom_range(1) ? 32'h7FFF_FFFF : 32'd0)
                                     : $urandom_range(0, 2000000));
    write_reg(REG_START_POS, extreme ? ($urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000)
                                     : $urandom);
    write_reg(REG_START_VEL, extreme ? ($urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000)
                                     : $urandom);
    write_reg(REG_PHASE_STEP, $urandom);
  endtask

  task automatic random_frames(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: send_item(OP_RESTART, 31'($urandom));
        1: send_item(OP_FRAME, 31'($urandom));
        2: send_item(OP_FRAME, 31'd0);
        default: send_item(OP_FRAME, 31'($urandom_range(0, 20000)));
      endcase
    end
  endtask

  initial begin
    board.reset_state();
    repeat (4) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: reset values, extremes, zero step, disabled run
    send_item(OP_FRAME, 31'd655);
    send_item(OP_FRAME, 31'd20000);
    send_item(OP_FRAME, 31'h7FFF_FFFF);
    send_item(OP_FRAME, 31'd0);
    send_item(OP_RESTART, 31'h7FFF_FFFF);
    send_item(OP_FRAME, 31'd1000);
    drain();
    write_reg(REG_RUN_ENABLE, 0);
    send_item(OP_FRAME, 31'd5000);
    send_item(OP_RESTART, 31'd0);
    drain();
    write_reg(REG_RUN_ENABLE, 1);
    write_reg(REG_FIXED_STEP, 0);
    write_reg(REG_TIME_SCALE, 32'hFFFF_FFFF);
    send_item(OP_FRAME, 31'h7FFF_FFFF);
    send_item(OP_FRAME, 31'h7FFF_FFFF);
    drain();
    write_reg(REG_FIXED_STEP, 1);
    write_reg(REG_STIFFNESS, 32'h7FFF_FFFF);
    write_reg(REG_START_POS, 32'h8000_0000);
    write_reg(REG_START_VEL, 32'h7FFF_FFFF);
    write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
    send_item(OP_RESTART, 31'd0);
    send_item(OP_FRAME, 31'd3);
    send_item(OP_FRAME, 31'd40);
    drain();
    write_reg(REG_TIME_SCALE, 0);
    write_reg(REG_START_POS, 32'h7FFF_FFFF);
    write_reg(REG_PHASE_STEP, 32'h4000_0000);
    send_item(OP_RESTART, 31'd5);
    send_item(OP_FRAME, 31'd7000);
    drain();
    // random phases; phase 6 runs with no idling
    for (int ph = 0; ph < 12; ph++) begin
      random_setting(ph % 3 == 2);
      if (ph == 6) idle_pct = 0;
      if (ph == 7) idle_pct = 35;
      send_item(OP_RESTART, 31'($urandom));
      random_frames(46);
      drain();
    end
    if (board.pending.size() != 0) board.errors++;
    if (board.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
